FILE: sv/aicr_pkg.sv
// ----------------------------------------------------------------------------
// aicr_pkg
// Shared widths, contact codes, register indexes and saturation helper for
// the AABB impulse collision resolver.
// ----------------------------------------------------------------------------
package aicr_pkg;

   localparam int unsigned WORD_W     = 32;
   localparam int unsigned DIM_W      = 31;
   localparam int unsigned COEF_W     = 17;
   localparam int unsigned ACC_W      = 64;
   localparam int unsigned DVD_W      = 61;
   localparam int unsigned SHARE_BITS = 30;
   localparam int unsigned SAT_W      = 40;
   localparam int unsigned CSR_IDX_W  = 2;

   localparam logic [2:0] NORM_NONE  = 3'd0;
   localparam logic [2:0] NORM_NEG_X = 3'd1;
   localparam logic [2:0] NORM_POS_X = 3'd2;
   localparam logic [2:0] NORM_NEG_Y = 3'd3;
   localparam logic [2:0] NORM_POS_Y = 3'd4;

   localparam logic [CSR_IDX_W-1:0] CSR_PERCENT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SLOP    = 2'd1;

   localparam logic signed [SAT_W-1:0] SAT_MAX = 40'sh00_7FFF_FFFF;
   localparam logic signed [SAT_W-1:0] SAT_MIN = 40'shFF_8000_0000;

   typedef logic signed [WORD_W-1:0] word_type;

   function automatic word_type sat32(input logic signed [SAT_W-1:0] v);
      word_type r;
      if (v > SAT_MAX) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < SAT_MIN) begin
         r = 32'sh8000_0000;
      end else begin
         r = v[WORD_W-1:0];
      end
      return r;
   endfunction

endpackage

FILE: sv/aabb_impulse_collision_resolver_core.sv
// Work per item: mode 0 runs four 31-step reciprocal multiplications; mode 1
//   without overlap, with both bodies immovable or separating ends after the
//   contact check; mode 1 with an impulse runs two 61-step divisions and five
//   shift-add multiplications of 17 to 31 steps. One item at a time, plus output stalls.
// Rate is set by the single shared 65-bit add/subtract unit, one bit a cycle.
// Synchronous reset clears body A state and restores register defaults.
// ----------------------------------------------------------------------------
// aabb_impulse_collision_resolver_core
// Integrates body A and resolves AABB contacts against body B with impulse
// and positional correction, using one iterative add/subtract unit.
// ----------------------------------------------------------------------------
module aabb_impulse_collision_resolver_core
   import aicr_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_we,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [COEF_W-1:0]           csr_wdata,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_mode,
   input  logic signed [WORD_W-1:0]    req_pos_x,
   input  logic signed [WORD_W-1:0]    req_pos_y,
   input  logic [DIM_W-1:0]            req_box_width,
   input  logic [DIM_W-1:0]            req_box_height,
   input  logic signed [WORD_W-1:0]    req_vel_x,
   input  logic signed [WORD_W-1:0]    req_vel_y,
   input  logic signed [WORD_W-1:0]    req_acc_x,
   input  logic signed [WORD_W-1:0]    req_acc_y,
   input  logic [DIM_W-1:0]            req_inv_mass,
   input  logic [COEF_W-1:0]           req_restitution,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic signed [WORD_W-1:0]    rsp_a_vel_x_out,
   output logic signed [WORD_W-1:0]    rsp_a_vel_y_out,
   output logic signed [WORD_W-1:0]    rsp_a_pos_x_out,
   output logic signed [WORD_W-1:0]    rsp_a_pos_y_out,
   output logic signed [WORD_W-1:0]    rsp_b_vel_x_out,
   output logic signed [WORD_W-1:0]    rsp_b_vel_y_out,
   output logic [2:0]                  rsp_contact_normal,
   output logic [DIM_W-1:0]            rsp_penetration_depth,
   output logic                        rsp_impulse_applied,
   output logic                        rsp_both_immovable
);

   localparam int SLOP_RESET_INT = ((5 << FRAC_BITS) + 50) / 100;
   localparam logic [COEF_W-1:0] SLOP_RESET = COEF_W'(SLOP_RESET_INT);
   localparam logic [COEF_W-1:0] PERCENT_RESET = 17'd32768;

   // rounded-up reciprocals: x/100 = (x*R100) >> 37, x/10 = (x*R10) >> 34,
   // exact for magnitudes up to 2^31
   localparam logic [SHARE_BITS:0] RECIP_100 = 31'd1374389535;
   localparam logic [SHARE_BITS:0] RECIP_10  = 31'd1717986919;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_EVAL  = 3'd1;
   localparam logic [2:0] ST_ISSUE = 3'd2;
   localparam logic [2:0] ST_MUL   = 3'd3;
   localparam logic [2:0] ST_DIV   = 3'd4;
   localparam logic [2:0] ST_POST  = 3'd5;
   localparam logic [2:0] ST_DONE  = 3'd6;

   localparam logic [3:0] STEP_AX = 4'd0;
   localparam logic [3:0] STEP_AY = 4'd1;
   localparam logic [3:0] STEP_VX = 4'd2;
   localparam logic [3:0] STEP_VY = 4'd3;
   localparam logic [3:0] STEP_W  = 4'd4;
   localparam logic [3:0] STEP_SA = 4'd5;
   localparam logic [3:0] STEP_SB = 4'd6;
   localparam logic [3:0] STEP_DA = 4'd7;
   localparam logic [3:0] STEP_DB = 4'd8;
   localparam logic [3:0] STEP_C  = 4'd9;
   localparam logic [3:0] STEP_DP = 4'd10;

   // control
   logic [2:0] state_ff;
   logic [3:0] step_ff;
   logic [5:0] iter_ff;

   // configuration
   logic [COEF_W-1:0] percent_ff;
   logic [COEF_W-1:0] slop_ff;

   // body A state
   logic signed [WORD_W-1:0] a_det_x_ff, a_det_y_ff;
   logic [DIM_W-1:0]         a_w_ff, a_h_ff;
   logic signed [WORD_W-1:0] a_vel_x_ff, a_vel_y_ff;
   logic signed [WORD_W-1:0] a_pos_x_ff, a_pos_y_ff;
   logic [DIM_W-1:0]         a_im_ff;
   logic [COEF_W-1:0]        a_el_ff;

   // latched item
   logic signed [WORD_W-1:0] in_px_ff, in_py_ff, in_vx_ff, in_vy_ff, in_ax_ff, in_ay_ff;
   logic [DIM_W-1:0]         in_bw_ff, in_bh_ff, in_im_ff;
   logic [COEF_W-1:0]        in_rest_ff;

   // contact working values
   logic                     on_x_ff, neg_ff;
   logic [32:0]              mag_ff;
   logic [WORD_W-1:0]        sum_ff;
   logic [COEF_W-1:0]        emin_ff;
   logic [34:0]              w_ff;
   logic [SHARE_BITS:0]      sa_ff, sb_ff;
   logic [33:0]              da_ff, db_ff;
   logic [WORD_W-1:0]        c_ff;
   logic signed [WORD_W-1:0] bvx_ff, bvy_ff;
   logic [2:0]               normal_ff;
   logic [DIM_W-1:0]         pen_ff;
   logic                     applied_ff, immov_ff;

   // shared unit operands
   logic [ACC_W-1:0]         acc_ff, mcand_ff;
   logic [SHARE_BITS:0]      mplier_ff;
   logic [DVD_W-1:0]         dvd_ff, q_ff;
   logic [WORD_W-1:0]        rem_ff, dsr_ff;
   logic                     qneg_ff;

   // output register
   logic                     rsp_valid_ff;
   logic signed [WORD_W-1:0] o_avx_ff, o_avy_ff, o_apx_ff, o_apy_ff, o_bvx_ff, o_bvy_ff;
   logic [2:0]               o_norm_ff;
   logic [DIM_W-1:0]         o_pen_ff;
   logic                     o_app_ff, o_imm_ff;

   // ---------------- shared add/subtract unit ----------------
   logic [ACC_W:0] unit_a, unit_b, unit_sum;
   logic           unit_sub, div_neg;

   always_comb begin
      unit_a   = '0;
      unit_b   = '0;
      unit_sub = 1'b0;
      if (state_ff == ST_MUL) begin
         unit_a = {1'b0, acc_ff};
         unit_b = mplier_ff[0] ? {1'b0, mcand_ff} : '0;
      end else if (state_ff == ST_DIV) begin
         unit_a   = {32'd0, rem_ff, dvd_ff[DVD_W-1]};
         unit_b   = {33'd0, dsr_ff};
         unit_sub = 1'b1;
      end
      unit_sum = unit_a + (unit_sub ? ~unit_b : unit_b) + {{ACC_W{1'b0}}, unit_sub};
   end
   assign div_neg = unit_sum[ACC_W];

   // ---------------- contact evaluation ----------------
   logic signed [33:0] end_ax, end_bx, end_ay, end_by, lo_x, lo_y, hi_x, hi_y;
   logic signed [34:0] ox, oy;
   logic signed [35:0] dx, dy, wdx, wdy, dist_x, dist_y;
   logic signed [33:0] dvel, vn, vn_neg;
   logic               overlap, on_x, neg;
   logic [WORD_W-1:0]  sum_in;

   always_comb begin
      end_ax = 34'(a_det_x_ff) + $signed({3'b000, a_w_ff});
      end_bx = 34'(in_px_ff) + $signed({3'b000, in_bw_ff});
      end_ay = 34'(a_det_y_ff) + $signed({3'b000, a_h_ff});
      end_by = 34'(in_py_ff) + $signed({3'b000, in_bh_ff});
      hi_x   = (end_ax < end_bx) ? end_ax : end_bx;
      hi_y   = (end_ay < end_by) ? end_ay : end_by;
      lo_x   = (a_det_x_ff > in_px_ff) ? 34'(a_det_x_ff) : 34'(in_px_ff);
      lo_y   = (a_det_y_ff > in_py_ff) ? 34'(a_det_y_ff) : 34'(in_py_ff);
      ox     = 35'(hi_x) - 35'(lo_x);
      oy     = 35'(hi_y) - 35'(lo_y);
      overlap = (ox > 35'sd0) && (oy > 35'sd0);
      on_x   = oy > ox;
      dx     = 36'(in_px_ff) - 36'(a_det_x_ff);
      dy     = 36'(in_py_ff) - 36'(a_det_y_ff);
      wdx    = $signed({5'd0, in_bw_ff}) - $signed({5'd0, a_w_ff});
      wdy    = $signed({5'd0, in_bh_ff}) - $signed({5'd0, a_h_ff});
      dist_x = (dx <<< 1) + wdx;
      dist_y = (dy <<< 1) + wdy;
      neg    = on_x ? dist_x[35] : dist_y[35];
      dvel   = on_x ? (34'(in_vx_ff) - 34'(a_vel_x_ff)) : (34'(in_vy_ff) - 34'(a_vel_y_ff));
      vn     = neg ? -dvel : dvel;
      vn_neg = -vn;
      sum_in = {1'b0, a_im_ff} + {1'b0, in_im_ff};
   end

   // ---------------- step helpers ----------------
   logic [WORD_W-1:0]        ax_mag, ay_mag, avx_mag, avy_mag, quo_mag;
   logic signed [SAT_W-1:0]  q_signed;
   logic signed [32:0]       excess_s;
   logic [DIM_W-1:0]         excess;
   logic signed [SAT_W-1:0]  da_s, db_s, dp_s;

   always_comb begin
      ax_mag   = in_ax_ff[WORD_W-1] ? WORD_W'(-in_ax_ff) : WORD_W'(in_ax_ff);
      ay_mag   = in_ay_ff[WORD_W-1] ? WORD_W'(-in_ay_ff) : WORD_W'(in_ay_ff);
      avx_mag  = a_vel_x_ff[WORD_W-1] ? WORD_W'(-a_vel_x_ff) : WORD_W'(a_vel_x_ff);
      avy_mag  = a_vel_y_ff[WORD_W-1] ? WORD_W'(-a_vel_y_ff) : WORD_W'(a_vel_y_ff);
      quo_mag  = (step_ff == STEP_VX || step_ff == STEP_VY) ? {2'b00, acc_ff[ACC_W-1:34]}
                                                           : {5'd0, acc_ff[ACC_W-1:37]};
      q_signed = qneg_ff ? -$signed({8'd0, quo_mag}) : $signed({8'd0, quo_mag});
      excess_s = $signed({2'b00, pen_ff}) - $signed({16'd0, slop_ff});
      excess   = excess_s[32] ? '0 : excess_s[DIM_W-1:0];
      da_s     = $signed({6'd0, da_ff});
      db_s     = $signed({6'd0, db_ff});
      dp_s     = $signed({6'd0, acc_ff[ACC_W-1:SHARE_BITS]});
   end

   assign req_ready = (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= STEP_AX;
         iter_ff      <= '0;
         percent_ff   <= PERCENT_RESET;
         slop_ff      <= SLOP_RESET;
         a_det_x_ff   <= '0;
         a_det_y_ff   <= '0;
         a_w_ff       <= '0;
         a_h_ff       <= '0;
         a_vel_x_ff   <= '0;
         a_vel_y_ff   <= '0;
         a_pos_x_ff   <= '0;
         a_pos_y_ff   <= '0;
         a_im_ff      <= '0;
         a_el_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            if (csr_index == CSR_PERCENT) begin
               percent_ff <= csr_wdata;
            end else if (csr_index == CSR_SLOP) begin
               slop_ff <= csr_wdata;
            end
         end

         // drop the beat once taken; a finishing item reloads it below
         if (rsp_valid_ff && rsp_ready && state_ff != ST_DONE) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  in_px_ff   <= req_pos_x;
                  in_py_ff   <= req_pos_y;
                  in_bw_ff   <= req_box_width;
                  in_bh_ff   <= req_box_height;
                  in_vx_ff   <= req_vel_x;
                  in_vy_ff   <= req_vel_y;
                  in_ax_ff   <= req_acc_x;
                  in_ay_ff   <= req_acc_y;
                  in_im_ff   <= req_inv_mass;
                  in_rest_ff <= req_restitution;
                  bvx_ff     <= req_vel_x;
                  bvy_ff     <= req_vel_y;
                  normal_ff  <= NORM_NONE;
                  pen_ff     <= '0;
                  applied_ff <= 1'b0;
                  immov_ff   <= 1'b0;
                  step_ff    <= STEP_AX;
                  state_ff   <= req_mode ? ST_EVAL : ST_ISSUE;
               end
            end

            ST_EVAL: begin
               on_x_ff <= on_x;
               neg_ff  <= neg;
               mag_ff  <= vn_neg[32:0];
               sum_ff  <= sum_in;
               emin_ff <= (a_el_ff < in_rest_ff) ? a_el_ff : in_rest_ff;
               if (!overlap) begin
                  state_ff <= ST_DONE;
               end else begin
                  pen_ff    <= on_x ? ox[DIM_W-1:0] : oy[DIM_W-1:0];
                  normal_ff <= on_x ? (neg ? NORM_NEG_X : NORM_POS_X)
                                    : (neg ? NORM_NEG_Y : NORM_POS_Y);
                  if (sum_in == '0) begin
                     immov_ff <= 1'b1;
                     state_ff <= ST_DONE;
                  end else if (vn > 34'sd0) begin
                     state_ff <= ST_DONE;
                  end else begin
                     applied_ff <= 1'b1;
                     step_ff    <= STEP_W;
                     state_ff   <= ST_ISSUE;
                  end
               end
            end

            ST_ISSUE: begin
               acc_ff <= '0;
               rem_ff <= '0;
               unique case (step_ff)
                  STEP_AX: begin
                     mcand_ff  <= {32'd0, ax_mag};
                     mplier_ff <= RECIP_100;
                     qneg_ff   <= in_ax_ff[WORD_W-1];
                     iter_ff   <= 6'd31;
                     state_ff  <= ST_MUL;
                  end
                  STEP_AY: begin
                     mcand_ff  <= {32'd0, ay_mag};
                     mplier_ff <= RECIP_100;
                     qneg_ff   <= in_ay_ff[WORD_W-1];
                     iter_ff   <= 6'd31;
                     state_ff  <= ST_MUL;
                  end
                  STEP_VX: begin
                     mcand_ff  <= {32'd0, avx_mag};
                     mplier_ff <= RECIP_10;
                     qneg_ff   <= a_vel_x_ff[WORD_W-1];
                     iter_ff   <= 6'd31;
                     state_ff  <= ST_MUL;
                  end
                  STEP_VY: begin
                     mcand_ff  <= {32'd0, avy_mag};
                     mplier_ff <= RECIP_10;
                     qneg_ff   <= a_vel_y_ff[WORD_W-1];
                     iter_ff   <= 6'd31;
                     state_ff  <= ST_MUL;
                  end
                  STEP_W: begin
                     mcand_ff  <= {31'd0, mag_ff};
                     mplier_ff <= {13'd0, 18'd65536 + {1'b0, emin_ff}};
                     iter_ff   <= 6'd18;
                     state_ff  <= ST_MUL;
                  end
                  STEP_SA: begin
                     dvd_ff   <= {a_im_ff, 30'd0};
                     dsr_ff   <= sum_ff;
                     iter_ff  <= 6'd61;
                     state_ff <= ST_DIV;
                  end
                  STEP_SB: begin
                     dvd_ff   <= {in_im_ff, 30'd0};
                     dsr_ff   <= sum_ff;
                     iter_ff  <= 6'd61;
                     state_ff <= ST_DIV;
                  end
                  STEP_DA: begin
                     mcand_ff  <= {29'd0, w_ff};
                     mplier_ff <= sa_ff;
                     iter_ff   <= 6'd31;
                     state_ff  <= ST_MUL;
                  end
                  STEP_DB: begin
                     mcand_ff  <= {29'd0, w_ff};
                     mplier_ff <= sb_ff;
                     iter_ff   <= 6'd31;
                     state_ff  <= ST_MUL;
                  end
                  STEP_C: begin
                     mcand_ff  <= {33'd0, excess};
                     mplier_ff <= {14'd0, percent_ff};
                     iter_ff   <= 6'd17;
                     state_ff  <= ST_MUL;
                  end
                  default: begin
                     mcand_ff  <= {32'd0, c_ff};
                     mplier_ff <= sa_ff;
                     iter_ff   <= 6'd31;
                     state_ff  <= ST_MUL;
                  end
               endcase
            end

            ST_MUL: begin
               acc_ff    <= unit_sum[ACC_W-1:0];
               mcand_ff  <= {mcand_ff[ACC_W-2:0], 1'b0};
               mplier_ff <= {1'b0, mplier_ff[SHARE_BITS:1]};
               iter_ff   <= iter_ff - 6'd1;
               if (iter_ff == 6'd1) begin
                  state_ff <= ST_POST;
               end
            end

            ST_DIV: begin
               rem_ff  <= div_neg ? {rem_ff[WORD_W-2:0], dvd_ff[DVD_W-1]}
                                  : unit_sum[WORD_W-1:0];
               q_ff    <= {q_ff[DVD_W-2:0], ~div_neg};
               dvd_ff  <= {dvd_ff[DVD_W-2:0], 1'b0};
               iter_ff <= iter_ff - 6'd1;
               if (iter_ff == 6'd1) begin
                  state_ff <= ST_POST;
               end
            end

            ST_POST: begin
               state_ff <= (step_ff == STEP_VY || step_ff == STEP_DP) ? ST_DONE : ST_ISSUE;
               step_ff  <= step_ff + 4'd1;
               unique case (step_ff)
                  STEP_AX: a_vel_x_ff <= sat32(SAT_W'(in_vx_ff) + q_signed);
                  STEP_AY: a_vel_y_ff <= sat32(SAT_W'(in_vy_ff) + q_signed);
                  STEP_VX: begin
                     a_pos_x_ff <= sat32(SAT_W'(in_px_ff) + q_signed);
                     a_det_x_ff <= sat32(SAT_W'(in_px_ff) + q_signed);
                  end
                  STEP_VY: begin
                     a_pos_y_ff <= sat32(SAT_W'(in_py_ff) + q_signed);
                     a_det_y_ff <= sat32(SAT_W'(in_py_ff) + q_signed);
                     a_w_ff     <= in_bw_ff;
                     a_h_ff     <= in_bh_ff;
                     a_im_ff    <= in_im_ff;
                     a_el_ff    <= in_rest_ff;
                  end
                  STEP_W:  w_ff  <= acc_ff[50:16];
                  STEP_SA: sa_ff <= q_ff[SHARE_BITS:0];
                  STEP_SB: sb_ff <= q_ff[SHARE_BITS:0];
                  STEP_DA: da_ff <= acc_ff[ACC_W-1:SHARE_BITS];
                  STEP_DB: db_ff <= acc_ff[ACC_W-1:SHARE_BITS];
                  STEP_C:  c_ff  <= acc_ff[47:16];
                  default: begin
                     // apply impulse and correction along the contact axis
                     if (on_x_ff) begin
                        a_vel_x_ff <= sat32(neg_ff ? SAT_W'(a_vel_x_ff) + da_s
                                                   : SAT_W'(a_vel_x_ff) - da_s);
                        bvx_ff     <= sat32(neg_ff ? SAT_W'(in_vx_ff) - db_s
                                                   : SAT_W'(in_vx_ff) + db_s);
                        a_pos_x_ff <= sat32(neg_ff ? SAT_W'(a_pos_x_ff) + dp_s
                                                   : SAT_W'(a_pos_x_ff) - dp_s);
                     end else begin
                        a_vel_y_ff <= sat32(neg_ff ? SAT_W'(a_vel_y_ff) + da_s
                                                   : SAT_W'(a_vel_y_ff) - da_s);
                        bvy_ff     <= sat32(neg_ff ? SAT_W'(in_vy_ff) - db_s
                                                   : SAT_W'(in_vy_ff) + db_s);
                        a_pos_y_ff <= sat32(neg_ff ? SAT_W'(a_pos_y_ff) + dp_s
                                                   : SAT_W'(a_pos_y_ff) - dp_s);
                     end
                  end
               endcase
            end

            ST_DONE: begin
               // hold until the output register is free
               if (!rsp_valid_ff || rsp_ready) begin
                  o_avx_ff     <= a_vel_x_ff;
                  o_avy_ff     <= a_vel_y_ff;
                  o_apx_ff     <= a_pos_x_ff;
                  o_apy_ff     <= a_pos_y_ff;
                  o_bvx_ff     <= bvx_ff;
                  o_bvy_ff     <= bvy_ff;
                  o_norm_ff    <= normal_ff;
                  o_pen_ff     <= pen_ff;
                  o_app_ff     <= applied_ff;
                  o_imm_ff     <= immov_ff;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end

            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_a_vel_x_out       = o_avx_ff;
   assign rsp_a_vel_y_out       = o_avy_ff;
   assign rsp_a_pos_x_out       = o_apx_ff;
   assign rsp_a_pos_y_out       = o_apy_ff;
   assign rsp_b_vel_x_out       = o_bvx_ff;
   assign rsp_b_vel_y_out       = o_bvy_ff;
   assign rsp_contact_normal    = o_norm_ff;
   assign rsp_penetration_depth = o_pen_ff;
   assign rsp_impulse_applied   = o_app_ff;
   assign rsp_both_immovable    = o_imm_ff;

`ifndef SYNTHESIS
   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_impulse_applied && rsp_both_immovable))
      else $error("impulse and immovable flags both set");

   a_no_contact_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_contact_normal == NORM_NONE) |->
      (rsp_penetration_depth == '0 && !rsp_impulse_applied && !rsp_both_immovable))
      else $error("flags or depth set without contact");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("ready while an item is in work");
`endif

endmodule

FILE: bench/aicr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aicr_checker
// Watches the request, response and register write ports of the resolver,
// keeps its own copy of body A and the correction registers, predicts each
// response beat and compares it field by field.
// ----------------------------------------------------------------------------
module aicr_checker
   import aicr_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_we,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [COEF_W-1:0]        csr_wdata,
   input  logic                     req_valid,
   input  logic                     req_ready,
   input  logic                     req_mode,
   input  logic signed [WORD_W-1:0] req_pos_x,
   input  logic signed [WORD_W-1:0] req_pos_y,
   input  logic [DIM_W-1:0]         req_box_width,
   input  logic [DIM_W-1:0]         req_box_height,
   input  logic signed [WORD_W-1:0] req_vel_x,
   input  logic signed [WORD_W-1:0] req_vel_y,
   input  logic signed [WORD_W-1:0] req_acc_x,
   input  logic signed [WORD_W-1:0] req_acc_y,
   input  logic [DIM_W-1:0]         req_inv_mass,
   input  logic [COEF_W-1:0]        req_restitution,
   input  logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  logic signed [WORD_W-1:0] rsp_a_vel_x_out,
   input  logic signed [WORD_W-1:0] rsp_a_vel_y_out,
   input  logic signed [WORD_W-1:0] rsp_a_pos_x_out,
   input  logic signed [WORD_W-1:0] rsp_a_pos_y_out,
   input  logic signed [WORD_W-1:0] rsp_b_vel_x_out,
   input  logic signed [WORD_W-1:0] rsp_b_vel_y_out,
   input  logic [2:0]               rsp_contact_normal,
   input  logic [DIM_W-1:0]         rsp_penetration_depth,
   input  logic                     rsp_impulse_applied,
   input  logic                     rsp_both_immovable,
   output int                       error_count,
   output int                       pending_count
);

   typedef struct packed {
      logic signed [WORD_W-1:0] avx, avy, apx, apy, bvx, bvy;
      logic [2:0]               normal;
      logic [DIM_W-1:0]         depth;
      logic                     applied;
      logic                     immovable;
   } contact_result_type;

   contact_result_type expected_q[$];

   longint unsigned pct, slop;
   longint det_x, det_y, a_w, a_h, a_vx, a_vy, a_px, a_py;
   longint unsigned a_im, a_e;

   function automatic longint clamp32(input longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   // Signed division truncating toward zero, as the hardware does.
   function automatic longint div_trunc(input longint n, input longint d);
      longint q;
      q = (n < 0 ? -n : n) / d;
      return n < 0 ? -q : q;
   endfunction

   function automatic contact_result_type resolve_contact(input logic mode,
         input longint px, input longint py, input longint bw, input longint bh,
         input longint vx, input longint vy, input longint ax, input longint ay,
         input longint unsigned im, input longint unsigned rest);
      contact_result_type r;
      longint ea, eb, fa, fb, ox, oy, ctr_dist, sgn, vn, da, db, dp, excess, pen;
      longint bvx, bvy;
      longint unsigned sum, e, w, sa, sb, c;
      logic on_x;
      bvx = vx; bvy = vy; pen = 0;
      r = '0;
      if (!mode) begin
         a_vx = clamp32(vx + div_trunc(ax, 100));
         a_vy = clamp32(vy + div_trunc(ay, 100));
         a_px = clamp32(px + div_trunc(a_vx * 10, 100));
         a_py = clamp32(py + div_trunc(a_vy * 10, 100));
         det_x = a_px; det_y = a_py;
         a_w = bw; a_h = bh; a_im = im; a_e = rest;
      end else begin
         ea = det_x + a_w; eb = px + bw;
         ox = (ea < eb ? ea : eb) - (det_x > px ? det_x : px);
         fa = det_y + a_h; fb = py + bh;
         oy = (fa < fb ? fa : fb) - (det_y > py ? det_y : py);
         if (ox > 0 && oy > 0) begin
            on_x = oy > ox;
            if (on_x) begin
               ctr_dist = 2 * (px - det_x) + (bw - a_w);
               r.normal = ctr_dist < 0 ? NORM_NEG_X : NORM_POS_X;
               pen = ox;
            end else begin
               ctr_dist = 2 * (py - det_y) + (bh - a_h);
               r.normal = ctr_dist < 0 ? NORM_NEG_Y : NORM_POS_Y;
               pen = oy;
            end
            sgn = ctr_dist < 0 ? -1 : 1;
            sum = a_im + im;
            vn = on_x ? sgn * (vx - a_vx) : sgn * (vy - a_vy);
            if (sum == 0) begin
               r.immovable = 1'b1;
            end else if (vn <= 0) begin
               e = a_e < rest ? a_e : rest;
               w = (longint'(-vn) * (65536 + e)) >> 16;
               sa = (a_im << SHARE_BITS) / sum;
               sb = (im << SHARE_BITS) / sum;
               da = longint'((w * sa) >> SHARE_BITS);
               db = longint'((w * sb) >> SHARE_BITS);
               excess = pen - longint'(slop);
               if (excess < 0) excess = 0;
               c = (longint'(excess) * pct) >> 16;
               dp = longint'((c * sa) >> SHARE_BITS);
               r.applied = 1'b1;
               if (on_x) begin
                  a_vx = clamp32(a_vx - sgn * da);
                  bvx = clamp32(vx + sgn * db);
                  a_px = clamp32(a_px - sgn * dp);
               end else begin
                  a_vy = clamp32(a_vy - sgn * da);
                  bvy = clamp32(vy + sgn * db);
                  a_py = clamp32(a_py - sgn * dp);
               end
            end
         end
      end
      r.avx = a_vx[31:0]; r.avy = a_vy[31:0];
      r.apx = a_px[31:0]; r.apy = a_py[31:0];
      r.bvx = bvx[31:0]; r.bvy = bvy[31:0];
      r.depth = pen[30:0];
      return r;
   endfunction

   assign pending_count = expected_q.size();

   always @(posedge clock) begin
      contact_result_type got, want;
      if (reset) begin
         pct <= 32768; slop <= 3277;
         det_x = 0; det_y = 0; a_w = 0; a_h = 0; a_vx = 0; a_vy = 0;
         a_px = 0; a_py = 0; a_im = 0; a_e = 0;
         expected_q.delete();
         error_count <= 0;
      end else begin
         if (csr_we) begin
            if (csr_index == CSR_PERCENT) pct <= csr_wdata;
            else if (csr_index == CSR_SLOP) slop <= csr_wdata;
         end
         if (req_valid && req_ready)
            expected_q.push_back(resolve_contact(req_mode, req_pos_x, req_pos_y,
               req_box_width, req_box_height, req_vel_x, req_vel_y, req_acc_x,
               req_acc_y, req_inv_mass, req_restitution));
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_a_vel_x_out, rsp_a_vel_y_out, rsp_a_pos_x_out,
                    rsp_a_pos_y_out, rsp_b_vel_x_out, rsp_b_vel_y_out,
                    rsp_contact_normal, rsp_penetration_depth,
                    rsp_impulse_applied, rsp_both_immovable};
            if (expected_q.size() == 0) begin
               $display("%0t: unexpected beat, actual %h", $time, got);
               error_count <= error_count + 1;
            end else begin
               want = expected_q.pop_front();
               if (got.avx != want.avx || got.avy != want.avy ||
                   got.apx != want.apx || got.apy != want.apy ||
                   got.bvx != want.bvx || got.bvy != want.bvy ||
                   got.normal != want.normal || got.depth != want.depth ||
                   got.applied != want.applied ||
                   got.immovable != want.immovable) begin
                  $display("%0t: mismatch expected avx %0d avy %0d apx %0d apy %0d",
                     $time, want.avx, want.avy, want.apx, want.apy,
                     " bvx %0d bvy %0d n %0d d %0d i %0b m %0b",
                     want.bvx, want.bvy, want.normal, want.depth, want.applied,
                     want.immovable);
                  $display("%0t:          actual   avx %0d avy %0d apx %0d apy %0d",
                     $time, got.avx, got.avy, got.apx, got.apy,
                     " bvx %0d bvy %0d n %0d d %0d i %0b m %0b",
                     got.bvx, got.bvy, got.normal, got.depth, got.applied,
                     got.immovable);
                  error_count <= error_count + 1;
               end
            end
         end
      end
   end

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives body A loads and body B contacts into the resolver with random
// gaps and response stalls, sweeps the correction registers between phases
// and reports the verdict from the checker's error count.
// ----------------------------------------------------------------------------
module tb_top
   import aicr_pkg::*;
();

   logic clock, reset;
   logic csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [COEF_W-1:0] csr_wdata;
   logic req_valid, req_ready, req_mode;
   logic signed [WORD_W-1:0] req_pos_x, req_pos_y, req_vel_x, req_vel_y;
   logic signed [WORD_W-1:0] req_acc_x, req_acc_y;
   logic [DIM_W-1:0] req_box_width, req_box_height, req_inv_mass;
   logic [COEF_W-1:0] req_restitution;
   logic rsp_valid, rsp_ready;
   logic signed [WORD_W-1:0] a_vx, a_vy, a_px, a_py, b_vx, b_vy;
   logic [2:0] normal;
   logic [DIM_W-1:0] depth;
   logic applied, immovable;
   int error_count, pending_count;
   int cycle_count;
   bit calm;

   aabb_impulse_collision_resolver_core u_top (
      .clock, .reset, .csr_we, .csr_index, .csr_wdata,
      .req_valid, .req_ready, .req_mode, .req_pos_x, .req_pos_y,
      .req_box_width, .req_box_height, .req_vel_x, .req_vel_y,
      .req_acc_x, .req_acc_y, .req_inv_mass, .req_restitution,
      .rsp_valid, .rsp_ready,
      .rsp_a_vel_x_out(a_vx), .rsp_a_vel_y_out(a_vy),
      .rsp_a_pos_x_out(a_px), .rsp_a_pos_y_out(a_py),
      .rsp_b_vel_x_out(b_vx), .rsp_b_vel_y_out(b_vy),
      .rsp_contact_normal(normal), .rsp_penetration_depth(depth),
      .rsp_impulse_applied(applied), .rsp_both_immovable(immovable));

   aicr_checker u_checker (
      .clock, .reset, .csr_we, .csr_index, .csr_wdata,
      .req_valid, .req_ready, .req_mode, .req_pos_x, .req_pos_y,
      .req_box_width, .req_box_height, .req_vel_x, .req_vel_y,
      .req_acc_x, .req_acc_y, .req_inv_mass, .req_restitution,
      .rsp_valid, .rsp_ready,
      .rsp_a_vel_x_out(a_vx), .rsp_a_vel_y_out(a_vy),
      .rsp_a_pos_x_out(a_px), .rsp_a_pos_y_out(a_py),
      .rsp_b_vel_x_out(b_vx), .rsp_b_vel_y_out(b_vy),
      .rsp_contact_normal(normal), .rsp_penetration_depth(depth),
      .rsp_impulse_applied(applied), .rsp_both_immovable(immovable),
      .error_count, .pending_count);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog: fails the run if about 600 items with stalls and gaps never finish.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 1500000) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // Stall the response side unless in the calm stretch.
   always @(negedge clock)
      rsp_ready <= reset ? 1'b0 : (calm || $urandom_range(99) >= 37);

   task automatic send_beat(input logic mode, input logic signed [31:0] px,
         input logic signed [31:0] py, input logic [30:0] bw, input logic [30:0] bh,
         input logic signed [31:0] vx, input logic signed [31:0] vy,
         input logic signed [31:0] ax, input logic signed [31:0] ay,
         input logic [30:0] im, input logic [16:0] rest);
      @(negedge clock);
      while (!calm && $urandom_range(99) < 37) @(negedge clock);
      req_valid <= 1'b1; req_mode <= mode;
      req_pos_x <= px; req_pos_y <= py; req_box_width <= bw; req_box_height <= bh;
      req_vel_x <= vx; req_vel_y <= vy; req_acc_x <= ax; req_acc_y <= ay;
      req_inv_mass <= im; req_restitution <= rest;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   task automatic wait_drained();
      while (pending_count != 0) @(negedge clock);
      repeat (300) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [16:0] val);
      @(negedge clock);
      csr_we <= 1'b1; csr_index <= idx; csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic logic [31:0] rand_word(input int sel);
      case (sel)
         0: return $urandom;
         1: return $signed($urandom_range(2000000)) - 1000000;
         default: return $signed($urandom_range(200000)) - 100000;
      endcase
   endfunction

   // Load A, mostly near the origin, then hit it with up to three nearby Bs of random shape.
   task automatic random_pair();
      logic signed [31:0] ax0, ay0;
      int s;
      s = $urandom_range(9) == 0 ? 0 : 2;
      ax0 = rand_word(s); ay0 = rand_word(s);
      send_beat(1'b0, ax0, ay0, 31'($urandom_range(400000)), 31'($urandom_range(400000)),
         rand_word(s), rand_word(s), rand_word(s), rand_word(s),
         31'($urandom_range(3) == 0 ? 0
            : ($urandom_range(9) == 0 ? $urandom : $urandom_range(300000))),
         17'($urandom_range(65536)));
      repeat ($urandom_range(3)) begin
         send_beat(1'b1, ax0 + rand_word(2), ay0 + rand_word(2),
            31'($urandom_range(9) == 0 ? $urandom : $urandom_range(300000)),
            31'($urandom_range(300000)), rand_word(s), rand_word(s),
            $urandom, $urandom,
            31'($urandom_range(3) == 0 ? 0 : $urandom_range(300000)),
            17'($urandom_range(9) == 0 ? $urandom : $urandom_range(65536)));
      end
   endtask

   initial begin
      logic [16:0] pct_set[4];
      logic [16:0] slop_set[4];
      pct_set = '{17'd0, 17'd65536, 17'h1FFFF, 17'd20000};
      slop_set = '{17'd0, 17'd65536, 17'h1FFFF, 17'd1000};
      reset = 1'b1; calm = 1'b0; cycle_count = 0;
      csr_we = 1'b0; csr_index = CSR_PERCENT; csr_wdata = '0;
      req_valid = 1'b0; req_mode = 1'b0; req_pos_x = '0; req_pos_y = '0;
      req_box_width = '0; req_box_height = '0; req_vel_x = '0; req_vel_y = '0;
      req_acc_x = '0; req_acc_y = '0; req_inv_mass = '0; req_restitution = '0;
      rsp_ready = 1'b0;
      repeat (8) @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      // Directed: extremes, saturation, each normal, immovable, separating.
      send_beat(1'b1, 0, 0, 100, 100, 0, 0, 0, 0, 0, 0);
      send_beat(1'b0, 32'h7FFFFFFF, 32'h80000000, 31'h7FFFFFFF, 31'h7FFFFFFF,
         32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 31'h7FFFFFFF, 17'h1FFFF);
      send_beat(1'b1, 32'h80000000, 32'h7FFFFFFF, 31'h7FFFFFFF, 31'h7FFFFFFF,
         32'h80000000, 32'h7FFFFFFF, 0, 0, 31'h7FFFFFFF, 17'h1FFFF);
      send_beat(1'b0, 0, 0, 65536*4, 65536*4, 65536, 0, 0, 0, 65536, 65536);
      send_beat(1'b1, 65536*3, 65536, 65536*4, 65536*2, -65536, 0, 0, 0, 65536, 65536);
      send_beat(1'b1, -65536*3, 65536, 65536*4, 65536*2, 65536*3, 0, 0, 0, 65536, 0);
      send_beat(1'b1, 65536, 65536*3, 65536*2, 65536*4, 0, -65536, 0, 0, 65536, 32768);
      send_beat(1'b1, 65536, -65536*3, 65536*2, 65536*4, 0, 65536, 0, 0, 0, 65536);
      send_beat(1'b1, 65536*2, 65536*2, 65536*4, 65536*4, 0, 0, 0, 0, 65536, 65536);
      send_beat(1'b1, 0, 0, 65536*4, 65536*4, 65536*9, 0, 0, 0, 65536, 65536);
      send_beat(1'b1, 65536*3, 65536*3, 65536*4, 65536*4, 65536*5, 65536*5, 0, 0, 1, 1);
      send_beat(1'b1, 65536*9, 0, 65536, 65536, 0, 0, 0, 0, 65536, 65536);
      send_beat(1'b0, 0, 0, 65536*4, 65536*4, 0, 0, 32'h7FFFFFFF, 32'h80000000, 0, 65536);
      send_beat(1'b1, 65536, 65536, 65536, 65536, 0, 0, 0, 0, 0, 65536);
      send_beat(1'b1, 65536, 65536*2, 65536, 65536, -65536*7, 0, 0, 0, 65536, 65536);

      for (int ph = 0; ph < 5; ph++) begin
         wait_drained();
         if (ph < 4) begin
            write_reg(CSR_PERCENT, pct_set[ph]);
            write_reg(CSR_SLOP, slop_set[(ph + 1) % 4]);
         end else begin
            write_reg(CSR_PERCENT, 17'd32768);
            write_reg(CSR_SLOP, 17'd3277);
         end
         calm = (ph == 2);
         for (int k = 0; k < 48; k++) random_pair();
      end

      wait_drained();
      if (error_count == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

endmodule

FILE: files.f
sv/aicr_pkg.sv
sv/aabb_impulse_collision_resolver_core.sv
bench/aicr_checker.sv
bench/tb_top.sv
